>>> design/motor_command_frame_packer_defines.svh
// ----------------------------------------------------------------------------
// Motor command frame packer assertion macros
// Shared concurrent check macros, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_FRAME_PACKER_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_PACKER_DEFINES_SVH

// Same-cycle implication check.
`define MCFP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mcfp: same-cycle check failed");

// Next-cycle implication check.
`define MCFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mcfp: next-cycle check failed");

`endif

>>> design/mcfp_pkg.sv
// ----------------------------------------------------------------------------
// Motor command frame packer package
// Widths, field offsets, register codes and fixed bounds shared by the design.
// ----------------------------------------------------------------------------
package mcfp_pkg;

    localparam int FRAC_BITS = 16;

    localparam int ADDR_W     = 10;
    localparam int ID_W       = 11;
    localparam int PAYLOAD_W  = 64;
    localparam int IN_W       = 32;
    localparam int POS_LIM_W  = 29;
    localparam int VEL_LIM_W  = 26;
    localparam int TRQ_LIM_W  = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 29;

    localparam int POS_CODE_W = 16;
    localparam int CODE_W     = 12;

    // Internal value width covers the input range and the largest gain bound.
    localparam int GAIN_W = FRAC_BITS + 9;
    localparam int VAL_W  = (GAIN_W + 1 > IN_W + 1) ? GAIN_W + 1 : IN_W + 1;
    localparam int SPAN_W = VAL_W - 1;
    localparam int QUO_W  = POS_CODE_W;
    localparam int NUM_W  = SPAN_W + QUO_W;

    localparam int FRONT_STG = 3;
    localparam int DIV_STG   = QUO_W;
    localparam int NSTG      = FRONT_STG + DIV_STG;

    localparam int NLANE     = 5;
    localparam int LANE_POS  = 0;
    localparam int LANE_VEL  = 1;
    localparam int LANE_KP   = 2;
    localparam int LANE_KD   = 3;
    localparam int LANE_TRQ  = 4;

    localparam int S_TDATA_W = ((ADDR_W + NLANE * IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + PAYLOAD_W + 7) / 8) * 8;
    localparam int ADDR_LSB  = 0;
    localparam int POS_LSB   = ADDR_LSB + ADDR_W;
    localparam int VEL_LSB   = POS_LSB + IN_W;
    localparam int KP_LSB    = VEL_LSB + IN_W;
    localparam int KD_LSB    = KP_LSB + IN_W;
    localparam int TRQ_LSB   = KD_LSB + IN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_LIMIT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TRQ_LIMIT = CFG_IDX_W'(2);

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [SPAN_W-1:0]       t_span;
    typedef logic [NUM_W-1:0]        t_num;
    typedef logic [QUO_W-1:0]        t_quo;
    typedef logic [NSTG-1:0]         t_stg_en;

    localparam logic [POS_LIM_W-1:0] POS_LIMIT_RESET = POS_LIM_W'(64'd191 << (FRAC_BITS - 1));
    localparam logic [VEL_LIM_W-1:0] VEL_LIMIT_RESET = VEL_LIM_W'(64'd45 << FRAC_BITS);
    localparam logic [TRQ_LIM_W-1:0] TRQ_LIMIT_RESET = TRQ_LIM_W'(64'd18 << FRAC_BITS);

    localparam t_val KP_BOUND = VAL_W'(64'd500 << FRAC_BITS);
    localparam t_val KD_BOUND = VAL_W'(64'd5 << FRAC_BITS);

    localparam logic [ID_W-1:0] ID_HIGH_BIT = ID_W'(1) << ADDR_W;

endpackage

>>> design/motor_command_frame_packer.sv
// ----------------------------------------------------------------------------
// Motor command frame packer
// A command word on the slave stream carries an address and five signed
// fixed-point values. Each value is clamped to its range, scaled to a 16-bit
// or 12-bit code with the fraction dropped, and the codes are packed
// big-endian into a 64-bit payload with identifier 0x400 or the address.
// The result word leaves on the master stream, one per command.
// The configuration channel writes the symmetric position, velocity and
// torque limits; the user must make writes while no command is in flight,
// as the block does not enforce it. The slave side takes one command per
// cycle while the receiver keeps taking results: three clamp and scale
// stages feed a 16-stage divider that resolves one quotient bit per stage.
// Reset clears all stage valid bits and restores the default limits.
// When the receiver stalls, the result holds and earlier stages keep filling
// any empty slots; the slave side stalls only when every stage is full.
// ----------------------------------------------------------------------------
module motor_command_frame_packer
    import mcfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // address, position, velocity, stiffness gain, damping gain, torque
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // frame identifier, frame payload
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [POS_LIM_W-1:0] r_pos_limit;
    logic [VEL_LIM_W-1:0] r_vel_limit;
    logic [TRQ_LIM_W-1:0] r_trq_limit;
    logic [ADDR_W-1:0]    r_addr [NSTG];

    t_stg_en               en;
    logic signed [IN_W-1:0] lane_x    [NLANE];
    t_val                  lane_lo   [NLANE];
    t_val                  lane_hi   [NLANE];
    t_span                 lane_span [NLANE];
    logic                  lane_wide [NLANE];
    t_num                  lane_num  [NLANE];
    t_quo                  lane_quo  [NLANE];
    t_val                  pos_hi;
    t_val                  vel_hi;
    t_val                  trq_hi;
    logic [ID_W-1:0]       frame_id;
    logic [PAYLOAD_W-1:0]  payload;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_limit <= POS_LIMIT_RESET;
            r_vel_limit <= VEL_LIMIT_RESET;
            r_trq_limit <= TRQ_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POS_LIMIT: r_pos_limit <= i_cfg_data[POS_LIM_W-1:0];
                CFG_VEL_LIMIT: r_vel_limit <= i_cfg_data[VEL_LIM_W-1:0];
                CFG_TRQ_LIMIT: r_trq_limit <= i_cfg_data[TRQ_LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mcfp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_m_ready (m_tready),
        .o_s_ready (s_tready),
        .o_m_valid (m_tvalid),
        .o_en      (en)
    );

    assign pos_hi = signed'(VAL_W'(r_pos_limit));
    assign vel_hi = signed'(VAL_W'(r_vel_limit));
    assign trq_hi = signed'(VAL_W'(r_trq_limit));

    assign lane_x[LANE_POS] = s_tdata[POS_LSB +: IN_W];
    assign lane_x[LANE_VEL] = s_tdata[VEL_LSB +: IN_W];
    assign lane_x[LANE_KP]  = s_tdata[KP_LSB +: IN_W];
    assign lane_x[LANE_KD]  = s_tdata[KD_LSB +: IN_W];
    assign lane_x[LANE_TRQ] = s_tdata[TRQ_LSB +: IN_W];

    assign lane_lo[LANE_POS] = -pos_hi;
    assign lane_lo[LANE_VEL] = -vel_hi;
    assign lane_lo[LANE_KP]  = '0;
    assign lane_lo[LANE_KD]  = '0;
    assign lane_lo[LANE_TRQ] = -trq_hi;

    assign lane_hi[LANE_POS] = pos_hi;
    assign lane_hi[LANE_VEL] = vel_hi;
    assign lane_hi[LANE_KP]  = KP_BOUND;
    assign lane_hi[LANE_KD]  = KD_BOUND;
    assign lane_hi[LANE_TRQ] = trq_hi;

    // An empty range clamps to zero; a divisor of one then gives a zero code.
    assign lane_span[LANE_POS] = (r_pos_limit == '0) ? SPAN_W'(1)
                                                     : SPAN_W'({r_pos_limit, 1'b0});
    assign lane_span[LANE_VEL] = (r_vel_limit == '0) ? SPAN_W'(1)
                                                     : SPAN_W'({r_vel_limit, 1'b0});
    assign lane_span[LANE_KP]  = SPAN_W'(KP_BOUND);
    assign lane_span[LANE_KD]  = SPAN_W'(KD_BOUND);
    assign lane_span[LANE_TRQ] = (r_trq_limit == '0) ? SPAN_W'(1)
                                                     : SPAN_W'({r_trq_limit, 1'b0});

    assign lane_wide[LANE_POS] = 1'b1;
    assign lane_wide[LANE_VEL] = 1'b0;
    assign lane_wide[LANE_KP]  = 1'b0;
    assign lane_wide[LANE_KD]  = 1'b0;
    assign lane_wide[LANE_TRQ] = 1'b0;

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        mcfp_scale u_scale (
            .i_clk   (i_clk),
            .i_en    (en[FRONT_STG-1:0]),
            .i_value (lane_x[l]),
            .i_lo    (lane_lo[l]),
            .i_hi    (lane_hi[l]),
            .i_wide  (lane_wide[l]),
            .o_num   (lane_num[l])
        );

        mcfp_div u_div (
            .i_clk  (i_clk),
            .i_en   (en[NSTG-1:FRONT_STG]),
            .i_num  (lane_num[l]),
            .i_span (lane_span[l]),
            .o_quo  (lane_quo[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_addr[0] <= s_tdata[ADDR_LSB +: ADDR_W];
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                r_addr[k] <= r_addr[k-1];
            end
        end
    end

    assign frame_id = ID_HIGH_BIT | ID_W'(r_addr[NSTG-1]);
    assign payload  = {lane_quo[LANE_POS][POS_CODE_W-1:0],
                       lane_quo[LANE_VEL][CODE_W-1:0],
                       lane_quo[LANE_KP][CODE_W-1:0],
                       lane_quo[LANE_KD][CODE_W-1:0],
                       lane_quo[LANE_TRQ][CODE_W-1:0]};
    assign m_tdata  = M_TDATA_W'({payload, frame_id});

endmodule

>>> design/mcfp_scale.sv
// ----------------------------------------------------------------------------
// Clamp and scale front end
// Clamps one value to its range, offsets it to zero and multiplies it by the
// full-scale code, over three register stages.
// ----------------------------------------------------------------------------
module mcfp_scale
    import mcfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic [FRONT_STG-1:0]   i_en,
    input  logic signed [IN_W-1:0] i_value,
    input  t_val                   i_lo,
    input  t_val                   i_hi,
    input  logic                   i_wide,
    output t_num                   o_num
);

    t_val  x_ext;
    t_val  diff;
    t_val  r_clamp;
    t_val  n_clamp;
    t_span r_offset;
    t_span n_offset;
    t_num  r_num;
    t_num  n_num;
    t_num  offset_ext;

    always_comb begin
        x_ext = VAL_W'(i_value);
        if (x_ext < i_lo) begin
            n_clamp = i_lo;
        end else if (x_ext > i_hi) begin
            n_clamp = i_hi;
        end else begin
            n_clamp = x_ext;
        end

        diff     = r_clamp - i_lo;
        n_offset = diff[SPAN_W-1:0];

        offset_ext = NUM_W'(r_offset);
        if (i_wide) begin
            n_num = (offset_ext << POS_CODE_W) - offset_ext;
        end else begin
            n_num = (offset_ext << CODE_W) - offset_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_clamp <= n_clamp;
        end
        if (i_en[1]) begin
            r_offset <= n_offset;
        end
        if (i_en[2]) begin
            r_num <= n_num;
        end
    end

    assign o_num = r_num;

endmodule

>>> design/mcfp_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per register stage; the user must hold the
// configuration-register divisor steady while items are in flight; unenforced.
// ----------------------------------------------------------------------------
module mcfp_div
    import mcfp_pkg::*;
(
    input  logic               i_clk,
    input  logic [DIV_STG-1:0] i_en,
    input  t_num               i_num,
    input  t_span              i_span,
    output t_quo               o_quo
);

    t_span r_rem [DIV_STG-1];
    t_quo  r_lq  [DIV_STG];

    for (genvar k = 0; k < DIV_STG; k++) begin : g_stage
        t_span          rem_in;
        t_quo           lq_in;
        logic [SPAN_W:0] trial;
        logic           q_bit;

        if (k == 0) begin : g_first
            assign rem_in = i_num[NUM_W-1:QUO_W];
            assign lq_in  = i_num[QUO_W-1:0];
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign lq_in  = r_lq[k-1];
        end

        assign trial = {rem_in, lq_in[QUO_W-1]};
        assign q_bit = (trial >= {1'b0, i_span});

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_lq[k] <= {lq_in[QUO_W-2:0], q_bit};
            end
        end

        if (k < DIV_STG - 1) begin : g_rem
            logic [SPAN_W:0] n_diff;
            t_span           n_rem;

            assign n_diff = trial - {1'b0, i_span};
            assign n_rem  = q_bit ? n_diff[SPAN_W-1:0] : trial[SPAN_W-1:0];

            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_quo = r_lq[DIV_STG-1];

endmodule

>>> design/mcfp_ctrl.sv
// ----------------------------------------------------------------------------
// Pipeline flow control
// Tracks a valid bit per stage and lets each stage load whenever no full
// run of stages up to the output is held by the receiver.
// ----------------------------------------------------------------------------
`include "motor_command_frame_packer_defines.svh"

module mcfp_ctrl
    import mcfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  logic    i_m_ready,
    output logic    o_s_ready,
    output logic    o_m_valid,
    output t_stg_en o_en
);

    localparam t_stg_en FULL = '1;

    t_stg_en r_valid;
    t_stg_en n_valid;
    t_stg_en ready;
    t_stg_en upper;
    logic    in_acc;
    logic    out_acc;

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            upper    = FULL << k;
            ready[k] = i_m_ready || ((r_valid & upper) != upper);
        end
        n_valid[0] = ready[0] ? i_s_valid : r_valid[0];
        for (int k = 1; k < NSTG; k++) begin
            n_valid[k] = ready[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_en      = ready;
    assign o_s_ready = ready[0];
    assign o_m_valid = r_valid[NSTG-1];

    assign in_acc  = i_s_valid && o_s_ready;
    assign out_acc = o_m_valid && i_m_ready;

    `MCFP_ASSERT_IMPL(a_blocked_only_when_full, !o_s_ready, (r_valid == FULL) && !i_m_ready)
    `MCFP_ASSERT_IMPL(a_open_when_drained, i_m_ready, o_s_ready)
    `MCFP_ASSERT_NEXT(a_count_hold, in_acc == out_acc, $countones(r_valid) == $past($countones(r_valid)))
    `MCFP_ASSERT_NEXT(a_count_up, in_acc && !out_acc, $countones(r_valid) == $past($countones(r_valid)) + 1)
    `MCFP_ASSERT_NEXT(a_count_down, !in_acc && out_acc, $countones(r_valid) + 1 == $past($countones(r_valid)))

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Motor command frame packer testbench
// Drives motor commands on the slave stream and writes the three range
// limits on the configuration channel while the block is idle. Every frame
// on the master stream is checked field by field against a local model of
// the clamp, scale and pack rules. Both stream sides idle at random, and
// there are stretches with no idling. One phase holds the receiver off long
// enough to fill the pipeline and stall the input.
// ----------------------------------------------------------------------------
module tb;
    import mcfp_pkg::*;

    localparam longint KP_MAX = longint'(500) << FRAC_BITS;
    localparam longint KD_MAX = longint'(5) << FRAC_BITS;
    localparam longint IN_MAX = 64'sh7FFFFFFF;
    localparam longint IN_MIN = -64'sh80000000;
    localparam logic [CFG_DATA_W-1:0] POS_LIMIT_HIGH = CFG_DATA_W'(429490176);
    localparam logic [CFG_DATA_W-1:0] VEL_LIMIT_HIGH = CFG_DATA_W'(42949017);
    localparam logic [CFG_DATA_W-1:0] TRQ_LIMIT_HIGH = CFG_DATA_W'(42949017);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_WAIT = 18;

    typedef struct {
        logic [ADDR_W-1:0]      addr;
        logic signed [IN_W-1:0] pos;
        logic signed [IN_W-1:0] vel;
        logic signed [IN_W-1:0] kp;
        logic signed [IN_W-1:0] kd;
        logic signed [IN_W-1:0] trq;
    } t_command;

    typedef struct {
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] payload;
    } t_frame;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // address, position, velocity, stiffness gain, damping gain, torque
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // frame identifier, frame payload
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [POS_LIM_W-1:0] pos_limit = POS_LIMIT_RESET;
    logic [VEL_LIM_W-1:0] vel_limit = VEL_LIMIT_RESET;
    logic [TRQ_LIM_W-1:0] trq_limit = TRQ_LIMIT_RESET;

    t_frame pending_frames[$];
    int     mismatches = 0;
    bit     sender_steady = 1'b0;
    bit     receiver_steady = 1'b0;
    int     hold_request = 0;

    motor_command_frame_packer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [15:0] scaled_code(longint x, longint lo, longint hi, int bits);
        bit [63:0] offs;
        bit [63:0] span;
        bit [63:0] top;
        if (hi <= lo) begin
            return '0;
        end
        if (x < lo) begin
            x = lo;
        end
        if (x > hi) begin
            x = hi;
        end
        offs = x - lo;
        span = hi - lo;
        top  = (64'd1 << bits) - 64'd1;
        return 16'((offs * top) / span);
    endfunction

    function automatic t_frame expected_frame(t_command c);
        t_frame      f;
        logic [15:0] p;
        logic [15:0] v;
        logic [15:0] kp;
        logic [15:0] kd;
        logic [15:0] t;
        p  = scaled_code(longint'(c.pos), -longint'(pos_limit), longint'(pos_limit),
                         POS_CODE_W);
        v  = scaled_code(longint'(c.vel), -longint'(vel_limit), longint'(vel_limit),
                         CODE_W);
        kp = scaled_code(longint'(c.kp), 0, KP_MAX, CODE_W);
        kd = scaled_code(longint'(c.kd), 0, KD_MAX, CODE_W);
        t  = scaled_code(longint'(c.trq), -longint'(trq_limit), longint'(trq_limit),
                         CODE_W);
        f.id      = ID_HIGH_BIT | ID_W'(c.addr);
        f.payload = {p, v[11:0], kp[11:0], kd[11:0], t[11:0]};
        return f;
    endfunction

    // Mostly values near the range with the bounds and their neighbors,
    // some fully random words.
    function automatic logic signed [IN_W-1:0] pick_value(longint lo, longint hi);
        longint margin;
        longint r;
        margin = (hi - lo) / 8;
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2: return IN_W'(lo);
            3: return IN_W'(hi);
            4: return IN_W'(lo - 1 - $urandom_range(0, 15));
            5: return IN_W'(hi + 1 + $urandom_range(0, 15));
            default: begin
                r = longint'($urandom_range(0, 32'(hi - lo + 2 * margin)));
                return IN_W'(lo - margin + r);
            end
        endcase
    endfunction

    function automatic t_command random_command();
        t_command c;
        c.addr = ADDR_W'($urandom());
        c.pos  = pick_value(-longint'(pos_limit), longint'(pos_limit));
        c.vel  = pick_value(-longint'(vel_limit), longint'(vel_limit));
        c.kp   = pick_value(0, KP_MAX);
        c.kd   = pick_value(0, KD_MAX);
        c.trq  = pick_value(-longint'(trq_limit), longint'(trq_limit));
        return c;
    endfunction

    function automatic t_command make_command(logic [ADDR_W-1:0] addr, longint pos,
                                              longint vel, longint kp, longint kd,
                                              longint trq);
        t_command c;
        c.addr = addr;
        c.pos  = IN_W'(pos);
        c.vel  = IN_W'(vel);
        c.kp   = IN_W'(kp);
        c.kd   = IN_W'(kd);
        c.trq  = IN_W'(trq);
        return c;
    endfunction

    task automatic send_command(input t_command c);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word = '0;
        word[ADDR_LSB +: ADDR_W] = c.addr;
        word[POS_LSB +: IN_W]    = c.pos;
        word[VEL_LSB +: IN_W]    = c.vel;
        word[KP_LSB +: IN_W]     = c.kp;
        word[KD_LSB +: IN_W]     = c.kd;
        word[TRQ_LSB +: IN_W]    = c.trq;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge i_clk); while (!s_tready);
        pending_frames.push_back(expected_frame(c));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_command(random_command());
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_POS_LIMIT: pos_limit = data[POS_LIM_W-1:0];
            CFG_VEL_LIMIT: vel_limit = data[VEL_LIM_W-1:0];
            CFG_TRQ_LIMIT: trq_limit = data[TRQ_LIM_W-1:0];
            default: ;
        endcase
        if (last) begin
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] pos,
                              input logic [CFG_DATA_W-1:0] vel,
                              input logic [CFG_DATA_W-1:0] trq);
        wait_idle();
        write_reg(CFG_POS_LIMIT, pos, 1'b0);
        write_reg(CFG_VEL_LIMIT, vel, 1'b0);
        write_reg(CFG_TRQ_LIMIT, trq, 1'b1);
    endtask

    task automatic test_directed_extremes();
        longint lp;
        longint lv;
        longint lt;
        lp = longint'(pos_limit);
        lv = longint'(vel_limit);
        lt = longint'(trq_limit);
        send_command(make_command(10'd0, 0, 0, 0, 0, 0));
        send_command(make_command(10'd1023, IN_MAX, IN_MAX, IN_MAX, IN_MAX, IN_MAX));
        send_command(make_command(10'h2AA, IN_MIN, IN_MIN, IN_MIN, IN_MIN, IN_MIN));
        send_command(make_command(10'h155, lp, lv, KP_MAX, KD_MAX, lt));
        send_command(make_command(10'h0F0, -lp, -lv, 0, 0, -lt));
        send_command(make_command(10'h30F, lp + 1, lv + 1, KP_MAX + 1, KD_MAX + 1, lt + 1));
        send_command(make_command(10'h0CC, -lp - 1, -lv - 1, -1, -1, -lt - 1));
        send_command(make_command(10'h333, lp - 1, lv - 1, KP_MAX - 1, KD_MAX - 1, lt - 1));
        send_command(make_command(10'h1FF, -lp + 1, -lv + 1, 1, 1, -lt + 1));
        send_command(make_command(10'h200, 1, -1, KP_MAX / 2, KD_MAX / 2, 64'sh8000));
        send_command(make_command(10'h3C3, -64'sh8000, 64'sh10000, 64'sh1FFFF, 64'shFFFF,
                                  -1));
    endtask

    task automatic test_limit_corners();
        // Empty spans give zero position, velocity and torque codes for every value.
        set_limits('0, '0, '0);
        send_command(make_command(10'h011, 0, 0, KP_MAX, KD_MAX, 0));
        send_command(make_command(10'h3EE, IN_MAX, IN_MAX, 0, 0, IN_MAX));
        send_command(make_command(10'h2DB, IN_MIN, IN_MIN, 5, 5, IN_MIN));
        // A write to the unused index must leave all limits at zero.
        wait_idle();
        write_reg(CFG_UNUSED, '1, 1'b1);
        send_command(make_command(10'h124, 64'sh12345, -64'sh12345, 64'sh30000, 64'sh8000,
                                  7));
        send_command(make_command(10'h249, -7, 7, -64'sh30000, 64'sh20000, -64'sh12345));
        // Full-width writes keep only the width of each register.
        set_limits('1, '1, '1);
        send_command(make_command(10'h0AA, IN_MAX, IN_MAX, KP_MAX, KD_MAX, IN_MAX));
        send_command(make_command(10'h355, IN_MIN, IN_MIN, 0, 0, IN_MIN));
        send_command(make_command(10'h0FF, 64'sh03FFFFFF, -64'sh03FFFFFF, 64'sh1, 64'sh1,
                                  64'sh04000000));
    endtask

    task automatic test_random_settings();
        set_limits(CFG_DATA_W'(POS_LIMIT_RESET), CFG_DATA_W'(VEL_LIMIT_RESET),
                   CFG_DATA_W'(TRQ_LIMIT_RESET));
        send_random(70);
        set_limits(CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1));
        send_random(70);
        set_limits(POS_LIMIT_HIGH, VEL_LIMIT_HIGH, TRQ_LIMIT_HIGH);
        send_random(70);
        repeat (2) begin
            set_limits(CFG_DATA_W'($urandom_range(1, POS_LIMIT_HIGH)),
                       CFG_DATA_W'($urandom_range(1, VEL_LIMIT_HIGH)),
                       CFG_DATA_W'($urandom_range(1, TRQ_LIMIT_HIGH)));
            send_random(70);
        end
        set_limits(CFG_DATA_W'($urandom_range(1, 1000)), CFG_DATA_W'($urandom_range(1, 1000)),
                   CFG_DATA_W'($urandom_range(1, 1000)));
        send_random(70);
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        hold_request  = 150;
        sender_steady = 1'b1;
        send_random(60);
        sender_steady = 1'b0;
        wait_idle();
    endtask

    task automatic test_back_to_back();
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        send_random(50);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        wait_idle();
    endtask

    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = receiver_steady ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    always @(posedge i_clk) begin : check_frames
        t_frame want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word %h", m_tdata);
                end
            end else begin
                want = pending_frames.pop_front();
                if (m_tdata[ID_W-1:0] !== want.id) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("frame id: expected %h, actual %h", want.id,
                                 m_tdata[ID_W-1:0]);
                    end
                end
                if (m_tdata[ID_W +: PAYLOAD_W] !== want.payload) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("payload: expected %h, actual %h", want.payload,
                                 m_tdata[ID_W +: PAYLOAD_W]);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_limit_corners();
        test_random_settings();
        test_output_backpressure();
        test_back_to_back();
        wait_idle();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/mcfp_pkg.sv
design/mcfp_scale.sv
design/mcfp_div.sv
design/mcfp_ctrl.sv
design/motor_command_frame_packer.sv
tb/sv/tb.sv
